>>> src/cdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, payload types and register codes of the 3D gradient block.
package cdg_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int DIFF_W      = 25;
  localparam int SLOPE_W     = 32;
  localparam int COEF_W      = 32;
  localparam int PROD_W      = 58;
  localparam int ROUND_SHIFT = 16;
  localparam int PLANE_W     = 12;
  localparam int NX_W        = 13;
  localparam int SIZE_YZ_W   = 7;
  localparam int NX_MAX      = 4096;
  localparam int SIZE_MIN    = 3;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_X          = 8'd0,
    REG_SIZE_Y          = 8'd1,
    REG_SIZE_Z          = 8'd2,
    REG_INV_TWO_SPACING = 8'd3
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [SLOPE_W-1:0]  slope_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  final_node;
  } diff_set_t;

  function automatic logic [15:0] clamp_size(input logic [15:0] v, input logic [15:0] hi);
    logic [15:0] r;
    if (v < 16'(SIZE_MIN)) begin
      r = 16'(SIZE_MIN);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/cdg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: position counters, duplicated plane store and neighbor differences.
module cdg_front #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 restart,
  input  wire logic [cdg_pkg::NX_W-1:0]             nx,
  input  wire logic [$clog2(MAX_ROWS + 1)-1:0]      ny,
  input  wire logic [$clog2(MAX_COLUMNS + 1)-1:0]   nz,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire cdg_pkg::sample_t                     potential,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output cdg_pkg::diff_set_t                        out_set
);
  import cdg_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int NYW   = $clog2(MAX_ROWS + 1);
  localparam int NZW   = $clog2(MAX_COLUMNS + 1);
  localparam int AW    = 1 + RW + CW;
  localparam int DEPTH = 2 ** AW;

  logic [PLANE_W-1:0] plane_count, plane_count_next;
  logic [RW-1:0]      row_count, row_count_next;
  logic [CW-1:0]      column_count, column_count_next;

  logic accept, leave;
  logic col_last, row_last, plane_last, produce, is_final, half;
  logic [AW-1:0] addr_wr, addr_up, addr_dn, addr_nx;

  logic    f1_valid, f1_produce, f1_final;
  sample_t f1_sample, rd_a, rd_b, rd_c, rd_d, hist1, hist2;

  // two copies of the store, each one write and two reads per cycle
  sample_t mem_a [DEPTH];
  sample_t mem_b [DEPTH];

  assign leave     = f1_valid && (!f1_produce || !out_stall);
  assign in_stall  = f1_valid && !leave;
  assign accept    = in_valid && !in_stall;
  assign out_valid = f1_valid && f1_produce;

  assign col_last   = (NZW'(column_count) == nz - NZW'(1));
  assign row_last   = (NYW'(row_count) == ny - NYW'(1));
  assign plane_last = (NX_W'(plane_count) == nx - NX_W'(1));

  assign produce = (plane_count >= PLANE_W'(2)) &&
                   (row_count != '0) && (NYW'(row_count) <= ny - NYW'(2)) &&
                   (column_count != '0) && (NZW'(column_count) <= nz - NZW'(2));
  assign is_final = plane_last && (NYW'(row_count) == ny - NYW'(2)) &&
                    (NZW'(column_count) == nz - NZW'(2));

  always_comb begin
    plane_count_next  = plane_count;
    row_count_next    = row_count;
    column_count_next = column_count;
    if (col_last) begin
      column_count_next = '0;
      if (row_last) begin
        row_count_next   = '0;
        plane_count_next = plane_last ? '0 : plane_count + PLANE_W'(1);
      end else begin
        row_count_next = row_count + RW'(1);
      end
    end else begin
      column_count_next = column_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      plane_count  <= '0;
      row_count    <= '0;
      column_count <= '0;
    end else if (accept) begin
      plane_count  <= plane_count_next;
      row_count    <= row_count_next;
      column_count <= column_count_next;
    end
  end

  // current plane lives in half plane_count[0], the previous one in the other half
  assign half    = plane_count[0];
  assign addr_wr = {half, row_count, column_count};
  assign addr_up = {~half, row_count + RW'(1), column_count};
  assign addr_dn = {~half, row_count - RW'(1), column_count};
  // raster successor in the previous plane; feeds the column neighbors
  assign addr_nx = col_last ? {~half, row_count + RW'(1), CW'(0)}
                            : {~half, row_count, column_count + CW'(1)};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= mem_a[addr_wr];
      rd_b <= mem_a[addr_up];
      mem_a[addr_wr] <= potential;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_c <= mem_b[addr_dn];
      rd_d <= mem_b[addr_nx];
      mem_b[addr_wr] <= potential;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (leave) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sample  <= potential;
      f1_produce <= produce;
      f1_final   <= is_final;
    end
  end

  // successor reads of the two previous samples give the lower column neighbor
  always_ff @(posedge clk) begin
    if (leave) begin
      hist1 <= rd_d;
      hist2 <= hist1;
    end
  end

  assign out_set.dx         = DIFF_W'(f1_sample) - DIFF_W'(rd_a);
  assign out_set.dy         = DIFF_W'(rd_b) - DIFF_W'(rd_c);
  assign out_set.dz         = DIFF_W'(rd_d) - DIFF_W'(hist2);
  assign out_set.final_node = f1_final;

endmodule
`default_nettype wire

>>> src/cdg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short queue of difference sets between the front and back ends.
module cdg_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cdg_pkg::diff_set_t in_set,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cdg_pkg::diff_set_t      out_set
);
  import cdg_pkg::*;

  diff_set_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push, pop;

  assign in_stall  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_set   = slots[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/cdg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: scale differences by the reciprocal, round, saturate and hold the result.
module cdg_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [cdg_pkg::COEF_W-1:0] inv_two_spacing,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire cdg_pkg::diff_set_t         in_set,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output cdg_pkg::slope_t                 slope_x,
  output cdg_pkg::slope_t                 slope_y,
  output cdg_pkg::slope_t                 slope_z,
  output logic                            final_node
);
  import cdg_pkg::*;

  localparam int Q_W = PROD_W - ROUND_SHIFT;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(2 ** (ROUND_SHIFT - 1));
  localparam slope_t SLOPE_MAX = 32'sh7FFF_FFFF;
  localparam slope_t SLOPE_MIN = 32'sh8000_0000;

  logic signed [COEF_W:0]   coef;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic                     b1_valid, b1_final;
  logic                     out_load, b1_load;

  // add half an LSB, floor, then clip to 32 bits
  function automatic slope_t round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic [Q_W-1:0]           q;
    logic [Q_W-SLOPE_W:0]     upper;
    slope_t                   r;
    biased = p + ROUND_BIAS;
    q      = biased[PROD_W-1:ROUND_SHIFT];
    upper  = q[Q_W-1:SLOPE_W-1];
    if ((&upper) || !(|upper)) begin
      r = q[SLOPE_W-1:0];
    end else if (q[Q_W-1]) begin
      r = SLOPE_MIN;
    end else begin
      r = SLOPE_MAX;
    end
    return r;
  endfunction

  assign coef     = $signed({1'b0, inv_two_spacing});
  assign out_load = !out_valid || !out_stall;
  assign b1_load  = !b1_valid || out_load;
  assign in_stall = !b1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b1_load) begin
        b1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load && in_valid) begin
      prod_x   <= in_set.dx * coef;
      prod_y   <= in_set.dy * coef;
      prod_z   <= in_set.dz * coef;
      b1_final <= in_set.final_node;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && b1_valid) begin
      slope_x    <= round_sat(prod_x);
      slope_y    <= round_sat(prod_y);
      slope_z    <= round_sat(prod_z);
      final_node <= b1_final;
    end
  end

endmodule
`default_nettype wire

>>> src/central_difference_gradient_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming central-difference gradient of a 3D potential grid.
//
// Input channel: in_valid / in_stall with one potential sample (Q8.16) per
// request, raster order with the column index fastest, then row, then plane.
// Output channel: out_valid / out_stall with slope_x, slope_y, slope_z (Q16.16,
// rounded and saturated) and final_node, one request per interior node.
// Boundary nodes take a sample but give no result.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Writing a size register restarts the grid at the next sample.
// Throughput: one sample per cycle while in_stall is low. Every sample does one
// write and two reads in each of two copies of the plane store, both ports busy every cycle.
// Path: a taken sample is registered in the front stage, then passes the queue,
// the multiply stage and the output register before it shows on out_valid.
// When the receiver stalls, the output register and the multiply stage hold,
// then the four-entry queue fills, and only then does in_stall rise.
// Reset: sizes return to 64 (clipped to the row and column limits), the
// reciprocal to 1.0, position counters and pipeline go empty. The plane store
// is not cleared; every read feeding a result is of data from the current grid.
module central_difference_gradient_3d #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire cdg_pkg::sample_t                potential,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output cdg_pkg::slope_t                      slope_x,
  output cdg_pkg::slope_t                      slope_y,
  output cdg_pkg::slope_t                      slope_z,
  output logic                                 final_node,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cdg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cdg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cdg_pkg::*;

  localparam int NYW      = $clog2(MAX_ROWS + 1);
  localparam int NZW      = $clog2(MAX_COLUMNS + 1);
  localparam int NY_RESET = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int NZ_RESET = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

  // sizes are stored already clipped to their legal ranges
  logic [NX_W-1:0]   nx_lim;
  logic [NYW-1:0]    ny_lim;
  logic [NZW-1:0]    nz_lim;
  logic [COEF_W-1:0] inv_two_spacing;
  logic              cfg_write, restart;

  logic      f_valid, q_stall, q_valid, b_stall;
  diff_set_t f_set, q_set;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  // the reciprocal alone does not restart the grid
  assign restart   = cfg_write && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                   cfg_index == REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      nx_lim          <= NX_W'(64);
      ny_lim          <= NYW'(NY_RESET);
      nz_lim          <= NZW'(NZ_RESET);
      inv_two_spacing <= COEF_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SIZE_X: begin
          nx_lim <= NX_W'(clamp_size(16'(cfg_data[NX_W-1:0]), 16'(NX_MAX)));
        end
        REG_SIZE_Y: begin
          ny_lim <= NYW'(clamp_size(16'(cfg_data[SIZE_YZ_W-1:0]), 16'(MAX_ROWS)));
        end
        REG_SIZE_Z: begin
          nz_lim <= NZW'(clamp_size(16'(cfg_data[SIZE_YZ_W-1:0]), 16'(MAX_COLUMNS)));
        end
        REG_INV_TWO_SPACING: begin
          inv_two_spacing <= cfg_data[COEF_W-1:0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // front: counts position, reads neighbors, forms the three differences
  cdg_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .nx        (nx_lim),
    .ny        (ny_lim),
    .nz        (nz_lim),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .potential (potential),
    .out_valid (f_valid),
    .out_stall (q_stall),
    .out_set   (f_set)
  );

  // queue: decouples the front from stalls in the back
  cdg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (q_stall),
    .in_set    (f_set),
    .out_valid (q_valid),
    .out_stall (b_stall),
    .out_set   (q_set)
  );

  // back: multiply, round, saturate, output register
  cdg_back u_back (
    .clk             (clk),
    .rst             (rst),
    .inv_two_spacing (inv_two_spacing),
    .in_valid        (q_valid),
    .in_stall        (b_stall),
    .in_set          (q_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slope_x         (slope_x),
    .slope_y         (slope_y),
    .slope_z         (slope_z),
    .final_node      (final_node)
  );

  // a full queue always has a request waiting for the back end
  assert property (@(posedge clk) disable iff (rst) q_stall |-> q_valid)
    else $error("queue reports full while empty");

  // the input side may only stall when the queue is full
  assert property (@(posedge clk) disable iff (rst) !q_stall |-> !in_stall)
    else $error("input stalled with room in the queue");

  // a request pushed into the queue is visible on the next cycle
  assert property (@(posedge clk) disable iff (rst) (f_valid && !q_stall) |=> q_valid)
    else $error("queued request lost");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the streaming 3D central-difference gradient block.
//
// A driver process presents queued potential samples on the input channel and
// a monitor process watches both channels at the rising edge. Every accepted
// sample runs through a local model of the block (two-plane store, position
// counters, rounding and saturation), which queues the gradient it must give.
// Each gradient that leaves the block is checked field by field against the
// oldest queued one. Register writes happen only while the block is idle.
module tb_top;
  import cdg_pkg::*;

  localparam int ROWS_MAX      = 64;
  localparam int COLS_MAX      = 64;
  localparam int RANDOM_ITEMS  = 1850;
  // The last samples run with neither side idling.
  localparam int CALM_TAIL     = 250;
  // Covers the pipeline registers and the queue, with margin for boundary samples
  // that give no result but are still in flight.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  // Longest quiet stretch in a good run: a settle pause, the longest send gap, the
  // longest receiver stall and the pipeline; taken many times over.
  localparam int QUIET_LIMIT   = 500;
  localparam int PRINT_CAP     = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 8'd255;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;
  localparam longint  SLOPE_MAX  = 64'sd2147483647;
  localparam longint  SLOPE_MIN  = -64'sd2147483648;

  localparam logic [CFG_DATA_W-1:0] UNITY        = 32'h0001_0000;
  localparam logic [CFG_DATA_W-1:0] HALF         = 32'h0000_8000;
  localparam logic [CFG_DATA_W-1:0] HIGH_JUNK_X  = 32'hFFFF_E000;
  localparam logic [CFG_DATA_W-1:0] HIGH_JUNK_YZ = 32'hFFFF_FF80;

  typedef struct packed {
    slope_t sx;
    slope_t sy;
    slope_t sz;
    logic   last;
  } grad_t;

  // Ports of the block; every input starts at a known value.
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  sample_t                potential = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  slope_t                 slope_x;
  slope_t                 slope_y;
  slope_t                 slope_z;
  logic                   final_node;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Model of the block: raw register contents, plane store, position.
  logic [NX_W-1:0]      planes_reg = 13'd64;
  logic [SIZE_YZ_W-1:0] rows_reg   = 7'd64;
  logic [SIZE_YZ_W-1:0] cols_reg   = 7'd64;
  logic [COEF_W-1:0]    inv_reg    = UNITY;
  sample_t              grid_mem [2][ROWS_MAX][COLS_MAX];
  int                   plane_at   = 0;
  int                   row_at     = 0;
  int                   col_at     = 0;

  grad_t   grad_due[$];
  sample_t sample_feed[$];

  int   fed_count     = 0;
  int   samples_taken = 0;
  int   grads_seen    = 0;
  int   reg_writes    = 0;
  int   settings_run  = 0;
  int   errors        = 0;
  int   quiet_cycles  = 0;
  int   send_gap      = 0;
  int   stall_left    = 0;
  bit   idle_on       = 1'b1;
  logic in_took       = 1'b0;

  central_difference_gradient_3d #(
    .MAX_ROWS   (ROWS_MAX),
    .MAX_COLUMNS(COLS_MAX)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .potential (potential),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slope_x   (slope_x),
    .slope_y   (slope_y),
    .slope_z   (slope_z),
    .final_node(final_node),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int fit_size(int v, int hi);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // (hi - lo) * 1/(2h): Q25.32 product, round half up to Q16.16, saturate.
  function automatic slope_t scale_diff(sample_t hi_s, sample_t lo_s);
    longint d;
    longint p;
    longint q;
    d = longint'(hi_s) - longint'(lo_s);
    p = d * longint'({32'd0, inv_reg});
    q = (p + 64'sd32768) >>> ROUND_SHIFT;
    if (q > SLOPE_MAX) q = SLOPE_MAX;
    else if (q < SLOPE_MIN) q = SLOPE_MIN;
    return q[SLOPE_W-1:0];
  endfunction

  // Size writes restart the grid; the reciprocal and unused indexes do not.
  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    bit restart;
    restart = 1'b1;
    case (idx)
      REG_SIZE_X: planes_reg = data[NX_W-1:0];
      REG_SIZE_Y: rows_reg = data[SIZE_YZ_W-1:0];
      REG_SIZE_Z: cols_reg = data[SIZE_YZ_W-1:0];
      REG_INV_TWO_SPACING: begin
        inv_reg = data;
        restart = 1'b0;
      end
      default: restart = 1'b0;
    endcase
    if (restart) begin
      plane_at = 0;
      row_at   = 0;
      col_at   = 0;
    end
  endfunction

  // Store one sample; queue the gradient of node (i-1, j, k) when interior.
  function automatic void take_sample(sample_t s);
    int    nx;
    int    ny;
    int    nz;
    int    i;
    int    j;
    int    k;
    int    cur;
    int    prv;
    grad_t g;
    nx = fit_size(planes_reg, NX_MAX);
    ny = fit_size(rows_reg, ROWS_MAX);
    nz = fit_size(cols_reg, COLS_MAX);
    i = plane_at;
    j = row_at;
    k = col_at;
    if (i < nx && j < ny && k < nz) begin
      cur = i & 1;
      prv = cur ^ 1;
      if (i >= 2 && i - 1 <= nx - 2 && j >= 1 && j <= ny - 2 && k >= 1 && k <= nz - 2) begin
        g.sx   = scale_diff(s, grid_mem[cur][j][k]);
        g.sy   = scale_diff(grid_mem[prv][j + 1][k], grid_mem[prv][j - 1][k]);
        g.sz   = scale_diff(grid_mem[prv][j][k + 1], grid_mem[prv][j][k - 1]);
        g.last = (i == nx - 1 && j == ny - 2 && k == nz - 2);
        grad_due.push_back(g);
      end
      grid_mem[cur][j][k] = s;
    end
    k++;
    if (k >= nz) begin
      k = 0;
      j++;
      if (j >= ny) begin
        j = 0;
        i++;
        if (i >= nx) i = 0;
      end
    end
    plane_at = i;
    row_at   = j;
    col_at   = k;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_CAP) $display("mismatch: %s", msg);
    errors++;
  endtask

  // Mostly full-range values, mostly tiny ones when gentle; extremes and tiny values for saturation and ties.
  function automatic sample_t pick_potential(bit gentle);
    logic [31:0] r;
    r = $urandom();
    if (gentle && r[31:30] != 2'b00) return sample_t'(int'($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_inverse();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'd1;
      2: return HALF;  // odd differences land exactly on a half
      3: return UNITY;
      4: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Drive the input channel: hold a stalled request, else advance or idle.
  always @(negedge clk) begin : drive_samples
    logic    nv;
    sample_t np;
    nv = in_valid;
    np = potential;
    if (rst) begin
      nv = 1'b0;
    end else if (!in_valid || in_took) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (sample_feed.size() > 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 8) - 1;
        end else begin
          nv = 1'b1;
          np = sample_feed.pop_front();
        end
      end
    end
    in_valid  <= nv;
    potential <= np;
  end

  // Drive the receiver stall in bursts of random length.
  always @(negedge clk) begin : drive_stall
    logic ns;
    ns = 1'b0;
    if (!rst) begin
      if (stall_left > 0) begin
        ns = 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ns = 1'b1;
        stall_left = $urandom_range(1, 8) - 1;
      end
    end
    out_stall <= ns;
  end

  // Sample both channels at the rising edge: check results, then model inputs.
  always @(posedge clk) begin : watch_ports
    grad_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        grads_seen++;
        if (grad_due.size() == 0) begin
          report_mismatch($sformatf("gradient %0d arrived with none pending", grads_seen));
        end else begin
          want = grad_due.pop_front();
          if (slope_x !== want.sx)
            report_mismatch($sformatf("gradient %0d slope_x %0d, want %0d",
                                      grads_seen, slope_x, want.sx));
          if (slope_y !== want.sy)
            report_mismatch($sformatf("gradient %0d slope_y %0d, want %0d",
                                      grads_seen, slope_y, want.sy));
          if (slope_z !== want.sz)
            report_mismatch($sformatf("gradient %0d slope_z %0d, want %0d",
                                      grads_seen, slope_z, want.sz));
          if (final_node !== want.last)
            report_mismatch($sformatf("gradient %0d final_node %b, want %b",
                                      grads_seen, final_node, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        take_sample(potential);
        samples_taken++;
      end
    end
  end

  // Drop the run when nothing moves on any channel for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic feed_sample(sample_t s);
    sample_feed.push_back(s);
    fed_count++;
  endtask

  // Hold the sender until every request is taken and every gradient is out,
  // then let boundary samples still in the pipeline drain.
  task automatic settle();
    while (sample_feed.size() != 0 || samples_taken != fed_count || grad_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One grid setting: optional register writes while idle, then a stream.
  // With split set, the sender stops halfway until all gradients are back.
  task automatic run_setting(logic [CFG_DATA_W-1:0] nx_raw, logic [CFG_DATA_W-1:0] ny_raw,
                             logic [CFG_DATA_W-1:0] nz_raw, logic [CFG_DATA_W-1:0] inv,
                             int count, bit set_sizes, bit set_inv, bit gentle,
                             bit poke_unused, bit split);
    settle();
    settings_run++;
    if (set_sizes) begin
      cfg_write(REG_SIZE_X, nx_raw);
      cfg_write(REG_SIZE_Y, ny_raw);
      cfg_write(REG_SIZE_Z, nz_raw);
    end
    if (set_inv) cfg_write(REG_INV_TWO_SPACING, inv);
    if (poke_unused)
      cfg_write(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
    for (int n = 0; n < count; n++) begin
      if (split && n == count / 2) settle();
      feed_sample(pick_potential(gentle));
    end
  endtask

  initial begin : stimulus
    sample_t              probe [27];
    logic [CFG_DATA_W-1:0] nxr;
    logic [CFG_DATA_W-1:0] nyr;
    logic [CFG_DATA_W-1:0] nzr;
    logic [CFG_DATA_W-1:0] invr;
    int                    cnt;
    int                    cells;
    int                    r;
    int                    phase_no;
    int                    random_fed;
    bit                    ss;
    bit                    si;
    bit                    gentle;
    bit                    poke;
    bit                    split;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Smallest grid, one interior node (1,1,1), largest reciprocal: x and y
    // differences saturate high and low, z gives a plain value.
    settings_run++;
    cfg_write(REG_SIZE_X, 32'd3);
    cfg_write(REG_SIZE_Y, 32'd3);
    cfg_write(REG_SIZE_Z, 32'd3);
    cfg_write(REG_INV_TWO_SPACING, '1);
    for (int n = 0; n < 27; n++) probe[n] = pick_potential(1'b1);
    probe[4]  = SAMPLE_MIN;  // (0,1,1)
    probe[22] = SAMPLE_MAX;  // (2,1,1)
    probe[10] = SAMPLE_MAX;  // (1,0,1)
    probe[16] = SAMPLE_MIN;  // (1,2,1)
    probe[12] = '0;          // (1,1,0)
    probe[14] = 24'sd1;      // (1,1,2)
    for (int n = 0; n < 13; n++) feed_sample(probe[n]);
    // Unused indexes mid-grid must leave the position counters alone.
    settle();
    cfg_write(REG_UNUSED_LO, '1);
    cfg_write(REG_UNUSED_HI, '1);
    for (int n = 13; n < 27; n++) feed_sample(probe[n]);

    phase_no   = 0;
    random_fed = 0;
    while (random_fed < RANDOM_ITEMS) begin
      if (random_fed >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      ss     = 1'b1;
      si     = 1'b1;
      gentle = 1'b0;
      poke   = 1'b0;
      split  = 1'b0;
      case (phase_no)
        0: begin
          // Size data with junk above the register width; half-step ties.
          nxr = HIGH_JUNK_X | 32'd3;
          nyr = HIGH_JUNK_YZ | 32'd4;
          nzr = HIGH_JUNK_YZ | 32'd3;
          invr = HALF;
          cnt = 80;
          gentle = 1'b1;
        end
        1: begin
          // Full row length, one whole grid up to its last node.
          nxr = 32'd3;
          nyr = 32'd3;
          nzr = COLS_MAX;
          invr = pick_inverse();
          cnt = 3 * 3 * COLS_MAX;
        end
        3: begin
          // Row count above the limit clamps to the full plane height.
          nxr = 32'd3;
          nyr = 32'd127;
          nzr = 32'd3;
          invr = UNITY;
          cnt = 3 * ROWS_MAX * 3;
          split = 1'b1;
        end
        5: begin
          // Plane count above the limit; stream only the first planes.
          nxr = 32'h1FFF;
          nyr = 32'd3;
          nzr = 32'd3;
          invr = '1;
          cnt = 60;
        end
        7: begin
          // Sizes below three clamp up; zero reciprocal.
          nxr = 32'd0;
          nyr = 32'd1;
          nzr = HIGH_JUNK_YZ | 32'd2;
          invr = '0;
          cnt = 50;
          poke = 1'b1;
        end
        default: begin
          nxr = $urandom_range(0, 6);
          nyr = $urandom_range(0, 5);
          nzr = $urandom_range(0, 7);
          invr = pick_inverse();
          r = $urandom_range(0, 9);
          ss = (r < 8);
          si = (r < 6) || (r == 8);
          gentle = ($urandom_range(0, 3) == 0);
          poke = ($urandom_range(0, 4) == 0) || (r == 9);
          split = ($urandom_range(0, 3) == 0);
          cells = fit_size(nxr, NX_MAX) * fit_size(nyr, ROWS_MAX) * fit_size(nzr, COLS_MAX);
          cnt = $urandom_range(cells / 2, cells * 2);
          // keep the total close to the planned number of samples
          if (cnt > RANDOM_ITEMS - random_fed) cnt = RANDOM_ITEMS - random_fed;
        end
      endcase
      run_setting(nxr, nyr, nzr, invr, cnt, ss, si, gentle, poke, split);
      random_fed += cnt;
      phase_no++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples over %0d grid settings with %0d register writes",
             samples_taken, settings_run, reg_writes);
    $display("checked %0d gradients, %0d mismatches", grads_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
